/* src/lsra_pkg.sv */
`default_nettype none

package lsra_pkg;

  localparam int PHYS_REGS     = 16;
  localparam int MAX_INTERVALS = 1024;
  localparam int POINT_BITS    = 16;

  localparam int SLOT_W = (PHYS_REGS > 1) ? $clog2(PHYS_REGS) : 1;
  localparam int IDX_W  = $clog2(MAX_INTERVALS);
  localparam int CNT_W  = $clog2(PHYS_REGS + 1);
  localparam int CFG_W  = 5;
  localparam int REG_W  = 4;

  typedef struct packed {
    logic [POINT_BITS-1:0] start_point;
    logic [POINT_BITS-1:0] end_point;
    logic                  first_of_function;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]      interval_index;
    logic [REG_W-1:0]      assigned_register;
    logic                  spill_happened;
    logic [IDX_W-1:0]      spilled_index;
    logic [POINT_BITS-1:0] spill_point;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

/* src/lsra_ctrl.sv */
`default_nettype none

module lsra_ctrl
  import lsra_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  ctrl_sts_t  sts,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_DONE: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_scan_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && sts.scan_last) |=> (state_r == S_DONE))
    else $error("scan did not end in result state");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !sts.out_free) |=> (state_r == S_DONE && in_stall))
    else $error("result state left while output register full");
`endif

endmodule

`default_nettype wire

/* src/lsra_dp.sv */
`default_nettype none

module lsra_dp
  import lsra_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  in_item_t             in_data,
  input  wire                  cfg_wr_en,
  input  wire [CFG_W-1:0]      cfg_wr_data,
  input  ctrl_cmd_t            cmd,
  output ctrl_sts_t            sts,
  output logic                 out_valid,
  input  wire                  out_stall,
  output out_item_t            out_data
);

  logic [CFG_W-1:0]      num_regs_r;
  logic [IDX_W-1:0]      next_idx_r;
  logic [IDX_W-1:0]      idx_r;
  logic [POINT_BITS-1:0] start_r;
  logic [POINT_BITS-1:0] end_r;
  logic [SLOT_W-1:0]     scan_r;
  logic                  found_r;
  logic [SLOT_W-1:0]     reg_r;
  logic [SLOT_W-1:0]     best_r;
  logic [POINT_BITS-1:0] best_end_r;
  logic [PHYS_REGS-1:0]  busy_r;
  logic [POINT_BITS-1:0] slot_end_r   [PHYS_REGS];
  logic [IDX_W-1:0]      slot_owner_r [PHYS_REGS];
  logic                  out_valid_r;
  out_item_t             out_r;

  logic [CNT_W-1:0]      act_cnt;
  logic [IDX_W-1:0]      idx_inc;
  logic                  cur_busy;
  logic [POINT_BITS-1:0] cur_end;
  logic                  cur_expire;
  logic                  cur_active;
  logic [SLOT_W-1:0]     sel;
  out_item_t             res;

  // clamp register count to 1..PHYS_REGS
  always_comb begin
    if (num_regs_r == '0) begin
      act_cnt = CNT_W'(1);
    end else if (32'(num_regs_r) > 32'(PHYS_REGS)) begin
      act_cnt = CNT_W'(PHYS_REGS);
    end else begin
      act_cnt = CNT_W'(num_regs_r);
    end
  end

  always_comb begin
    if (32'(next_idx_r) == MAX_INTERVALS - 1) begin
      idx_inc = '0;
    end else begin
      idx_inc = next_idx_r + 1'b1;
    end
  end

  assign cur_busy   = busy_r[scan_r];
  assign cur_end    = slot_end_r[scan_r];
  assign cur_expire = cur_busy && (cur_end < start_r);
  assign cur_active = 32'(scan_r) < 32'(act_cnt);
  assign sel        = found_r ? reg_r : best_r;

  always_comb begin
    res                   = '0;
    res.interval_index    = idx_r;
    res.assigned_register = REG_W'(sel);
    res.spill_happened    = !found_r;
    if (!found_r) begin
      res.spilled_index = slot_owner_r[sel];
      res.spill_point   = start_r;
    end
  end

  assign sts.scan_last = (32'(scan_r) == PHYS_REGS - 1);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_regs_r  <= CFG_W'(16);
      next_idx_r  <= '0;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) num_regs_r <= cfg_wr_data;

      if (cmd.accept) begin
        if (in_data.first_of_function) begin
          busy_r     <= '0;
          next_idx_r <= (MAX_INTERVALS == 1) ? '0 : IDX_W'(1);
        end else begin
          next_idx_r <= idx_inc;
        end
      end else if (cmd.scan) begin
        if (cur_expire) busy_r[scan_r] <= 1'b0;
      end else if (cmd.commit) begin
        if (found_r) busy_r[sel] <= 1'b1;
      end

      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and per-item working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r      <= in_data.first_of_function ? '0 : next_idx_r;
      start_r    <= in_data.start_point;
      end_r      <= in_data.end_point;
      scan_r     <= '0;
      found_r    <= 1'b0;
      reg_r      <= '0;
      best_r     <= '0;
      best_end_r <= '0;
    end else if (cmd.scan) begin
      scan_r <= scan_r + 1'b1;
      if (cur_active && (!cur_busy || cur_expire) && !found_r) begin
        found_r <= 1'b1;
        reg_r   <= scan_r;
      end
      // greatest end wins, lowest index on ties
      if (cur_active && (scan_r == '0 || cur_end > best_end_r)) begin
        best_r     <= scan_r;
        best_end_r <= cur_end;
      end
    end

    if (cmd.commit) begin
      slot_end_r[sel]   <= end_r;
      slot_owner_r[sel] <= idx_r;
      out_r             <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("result loaded over an untaken transfer");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_reg_active: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (32'(sel) < 32'(act_cnt)))
    else $error("assigned register outside active count");
`endif

endmodule

`default_nettype wire

/* src/linear_scan_register_assign.sv */
`default_nettype none

// linear scan register assignment
// input channel (in_valid / in_stall / in_data): one live interval per
//   transfer, in ascending start order; first_of_function frees every
//   register and restarts interval numbering at zero
// result channel (out_valid / out_stall / out_data): one result per interval
//   with its number, its register, and the evicted interval if any
// cfg_wr_en / cfg_wr_data: number of active registers, written while idle;
//   zero acts as one, values above the slot count saturate
// sequence: accept, then the expiry/allocation scan over the 16-slot table at
//   one register slot per cycle, then commit; in_stall stays high through the
//   scan and the commit step, so no new interval is taken before the commit
// the next interval is taken while a result still waits in the output
//   register; if the receiver stalls, the block holds its result and waits
//   in the commit step with in_stall high
// reset: all registers free, numbering at zero, register count sixteen,
//   no result pending

module linear_scan_register_assign
  import lsra_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  wire              out_stall,
  output out_item_t        out_data,
  input  wire              cfg_wr_en,
  input  wire [CFG_W-1:0]  cfg_wr_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: accept, scan slots, commit result
  lsra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot table, scan registers and output register
  lsra_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

/* test/tb_linear_scan_register_assign.sv */
`default_nettype none

module tb_linear_scan_register_assign;
  import lsra_pkg::*;

  // cycles with no transfer on either channel before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  // settle time after the last result
  localparam int TAIL_CYCLES = 40;
  localparam int IDLE_PCT    = 37;
  localparam int PHASES      = 10;

  logic             clk;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  in_item_t         in_data     = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  out_item_t        out_data;
  logic             cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  // intervals not yet offered, and results owed by the block in order
  in_item_t  pending_intervals[$];
  out_item_t awaited_results[$];

  // shadow of the allocator state
  logic [PHYS_REGS-1:0]  occupied;
  logic [POINT_BITS-1:0] live_until[PHYS_REGS];
  logic [IDX_W-1:0]      holder[PHYS_REGS];
  logic [IDX_W-1:0]      fn_seq;
  logic [CFG_W-1:0]      reg_limit;

  int          errors = 0;
  int          quiet_cycles = 0;
  bit          steady = 1'b0;       // no idling on either side while set
  int unsigned cursor = 0;          // start point of the last queued interval
  logic [CFG_W-1:0] cfg_plan[PHASES];
  int          budget;
  int          chunk;

  linear_scan_register_assign DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    // keep the log short on a badly broken block, but count everything
    if (errors < 100) $display("mismatch: %s", msg);
    errors++;
  endtask

  // expected allocation for one interval; updates the shadow state
  function automatic out_item_t assign_interval(in_item_t iv);
    out_item_t   r;
    int unsigned lim;
    int unsigned pick;
    bit          got;
    // zero acts as one, anything above the slot count saturates
    lim = 32'(reg_limit);
    if (lim == 0) lim = 1;
    if (lim > PHYS_REGS) lim = PHYS_REGS;
    if (iv.first_of_function) begin
      occupied = '0;
      fn_seq   = '0;
    end
    r = '0;
    r.interval_index = fn_seq;
    fn_seq = fn_seq + 1'b1;   // wraps at the index width
    // expiry covers every slot, even those above the active count
    for (int s = 0; s < PHYS_REGS; s++) begin
      if (occupied[s] && live_until[s] < iv.start_point) occupied[s] = 1'b0;
    end
    got  = 1'b0;
    pick = 0;
    for (int s = 0; s < lim; s++) begin
      if (!got && !occupied[s]) begin
        pick = s;
        got  = 1'b1;
      end
    end
    if (got) begin
      occupied[pick] = 1'b1;
    end else begin
      // all active slots taken: evict the latest end, lowest slot on ties
      pick = 0;
      for (int s = 1; s < lim; s++) begin
        if (live_until[s] > live_until[pick]) pick = s;
      end
      r.spill_happened = 1'b1;
      r.spilled_index  = holder[pick];
      r.spill_point    = iv.start_point;
    end
    live_until[pick]    = iv.end_point;
    holder[pick]        = r.interval_index;
    r.assigned_register = REG_W'(pick);
    return r;
  endfunction

  task automatic compare_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing outstanding", got));
    end else begin
      want = awaited_results.pop_front();
      compare_field("interval_index", 32'(got.interval_index),
                    32'(want.interval_index));
      compare_field("assigned_register", 32'(got.assigned_register),
                    32'(want.assigned_register));
      compare_field("spill_happened", 32'(got.spill_happened),
                    32'(want.spill_happened));
      compare_field("spilled_index", 32'(got.spilled_index),
                    32'(want.spilled_index));
      compare_field("spill_point", 32'(got.spill_point), 32'(want.spill_point));
    end
  endtask

  // input side: offer queued intervals, idling at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // transfer at this edge: predict its result now
      if (in_valid && !in_stall) awaited_results.push_back(assign_interval(in_data));
      // a stalled payload stays put; otherwise pick the next one or idle
      if (!in_valid || !in_stall) begin
        if (pending_intervals.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_data  <= pending_intervals.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: random stall, compare each transfer, watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic push_interval(int unsigned s, int unsigned e, bit first);
    in_item_t iv;
    iv.start_point       = POINT_BITS'(s);
    iv.end_point         = POINT_BITS'(e);
    iv.first_of_function = first;
    pending_intervals.push_back(iv);
  endtask

  // a run of intervals in ascending start order, fresh or continuing the last
  task automatic queue_function(int n, bit fresh);
    int unsigned s;
    int unsigned e;
    bit          crowd;
    crowd = 1'($urandom_range(1));
    if (fresh) cursor = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(2000);
    for (int k = 0; k < n; k++) begin
      cursor = cursor + $urandom_range(crowd ? 3 : 30);
      s = cursor;
      case ($urandom_range(19))
        0:       e = s - $urandom_range(1, 50);   // ends before it starts
        1:       e = $urandom;
        default: e = s + $urandom_range(crowd ? 120 : 40);
      endcase
      push_interval(s, e, fresh && (k == 0));
    end
  endtask

  // unordered intervals with random flags
  task automatic queue_noise(int n);
    for (int k = 0; k < n; k++)
      push_interval($urandom, $urandom, $urandom_range(7) == 0);
  endtask

  // hold until every queued interval has gone in and every result come back
  task automatic wait_for_drain();
    @(negedge clk);
    while (pending_intervals.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg_count(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    reg_limit    = v;
  endtask

  initial begin
    occupied  = '0;
    fn_seq    = '0;
    reg_limit = CFG_W'(16);
    cfg_plan  = '{CFG_W'(1), CFG_W'(16), CFG_W'(0), CFG_W'(31), CFG_W'(17),
                  CFG_W'(3), CFG_W'(8), CFG_W'(2), CFG_W'(12), CFG_W'(5)};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset count of sixteen: field extremes, reuse after expiry, end before start
    push_interval(0, 0, 1'b1);
    push_interval(0, 65535, 1'b0);
    push_interval(1, 1, 1'b0);
    push_interval(5, 2, 1'b0);
    push_interval(6, 10, 1'b0);
    push_interval(65535, 65535, 1'b0);
    wait_for_drain();

    // two registers: evictions by latest end, then a tie on the end point
    write_reg_count(CFG_W'(2));
    push_interval(10, 100, 1'b1);
    push_interval(11, 50, 1'b0);
    push_interval(12, 200, 1'b0);
    push_interval(13, 300, 1'b0);
    push_interval(20, 400, 1'b1);
    push_interval(21, 400, 1'b0);
    push_interval(22, 30, 1'b0);
    wait_for_drain();

    // count of zero behaves as a single register
    write_reg_count(CFG_W'(0));
    push_interval(0, 5, 1'b1);
    push_interval(1, 6, 1'b0);
    push_interval(7, 8, 1'b0);

    // random phases; each waits for a full drain before the count changes,
    // and a phase may carry on the previous function under the new count
    for (int p = 0; p < PHASES; p++) begin
      wait_for_drain();
      steady = 1'b0;
      write_reg_count((p == PHASES - 1) ? CFG_W'($urandom_range(31)) : cfg_plan[p]);
      steady = (p == 2);
      if (p == 5) begin
        // one long function so the interval numbering wraps
        queue_function(1100, 1'($urandom_range(1)));
      end else begin
        budget = 75;
        while (budget > 0) begin
          chunk = $urandom_range(1, 30);
          if (chunk > budget) chunk = budget;
          if ($urandom_range(9) == 0) queue_noise(chunk);
          else queue_function(chunk, (budget == 75) ? 1'($urandom_range(1)) : 1'b1);
          budget -= chunk;
        end
      end
    end

    wait_for_drain();
    steady = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
